// File: hw/rtl/per_client_spam_rate_limiter_defines.svh
// assertion macros shared by the rate limiter rtl
// no dependencies; take in with `include before the module that asserts
`ifndef PER_CLIENT_SPAM_RATE_LIMITER_DEFINES_SVH
`define PER_CLIENT_SPAM_RATE_LIMITER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define PCSRL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCSRL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/pcsrl_pkg.sv
// shared constants, codes and types of the per-client rate limiter
// no dependencies
`timescale 1ns / 1ps

package pcsrl_pkg;

   localparam int CLIENT_SLOTS = 64;
   localparam int SLOT_W       = $clog2(CLIENT_SLOTS);
   localparam int SLOT_IN_W    = 6;
   localparam int COUNT_W      = 9;
   localparam int TIMER_W      = 8;
   localparam int CFG_W        = 8;
   localparam int VERDICT_W    = 2;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_IDX_W    = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // request kinds
   localparam logic REQ_MSG  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // verdict codes
   localparam logic [VERDICT_W-1:0] V_ALLOWED  = 2'd0;
   localparam logic [VERDICT_W-1:0] V_LOCKED   = 2'd1;
   localparam logic [VERDICT_W-1:0] V_NEW_LOCK = 2'd2;
   localparam logic [VERDICT_W-1:0] V_TICK     = 2'd3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_MSG_LIMIT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_LOCKOUT   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 2'd2;

   localparam logic [CFG_W-1:0] RST_MSG_LIMIT = 8'd5;
   localparam logic [CFG_W-1:0] RST_LOCKOUT   = 8'd10;
   localparam logic [CFG_W-1:0] RST_WINDOW    = 8'd5;

   typedef struct packed {
      logic [CFG_W-1:0] message_limit;
      logic [CFG_W-1:0] lockout_seconds;
      logic [CFG_W-1:0] window_ticks;
   } cfg_type;

endpackage

// File: hw/rtl/pcsrl_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pcsrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pcsrl_csr.sv
// configuration registers behind an apb-style port
// depends on pcsrl_pkg
`timescale 1ns / 1ps

module pcsrl_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pcsrl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pcsrl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pcsrl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output pcsrl_pkg::cfg_type                 cfg
);

   import pcsrl_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_hit;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (reg_idx)
            REG_MSG_LIMIT: cfg_in.message_limit   = csr_pwdata[CFG_W-1:0];
            REG_LOCKOUT:   cfg_in.lockout_seconds = csr_pwdata[CFG_W-1:0];
            REG_WINDOW:    cfg_in.window_ticks    = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MSG_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.message_limit);
         REG_LOCKOUT:   csr_prdata = CSR_DATA_W'(cfg_ff.lockout_seconds);
         REG_WINDOW:    csr_prdata = CSR_DATA_W'(cfg_ff.window_ticks);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.message_limit   <= RST_MSG_LIMIT;
         cfg_ff.lockout_seconds <= RST_LOCKOUT;
         cfg_ff.window_ticks    <= RST_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/per_client_spam_rate_limiter.sv
// per-client message rate limiter with lockout; for a message word the slot's count
// and timer are read from ram, then decided and written back once the output is free
// a tick word walks the timers of slots 1..last, one timer a cycle through the timer ram
// a result sits in an output register, so the next word is taken while it waits
// reset is synchronous: config returns to defaults, counts and timers read as
// zero at once through per-slot valid flops, no clearing pass
`timescale 1ns / 1ps

`include "per_client_spam_rate_limiter_defines.svh"

module per_client_spam_rate_limiter (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [pcsrl_pkg::SLOT_IN_W-1:0]     req_client_slot,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pcsrl_pkg::VERDICT_W-1:0]     rsp_verdict,
   output logic [pcsrl_pkg::TIMER_W-1:0]       rsp_wait_seconds,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pcsrl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pcsrl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pcsrl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   import pcsrl_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a word
   localparam logic [1:0] ST_MSG   = 2'd1;  // slot data back from ram, decide
   localparam logic [1:0] ST_SWEEP = 2'd2;  // reading timers 1..last
   localparam logic [1:0] ST_TDONE = 2'd3;  // last writeback, post tick result

   localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(CLIENT_SLOTS - 1);

   cfg_type cfg;

   logic [1:0]              state_ff, state_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic                    slot_ok_ff, slot_ok_in;
   logic [SLOT_W-1:0]       sweep_idx_ff, sweep_idx_in;
   logic                    wb_vld_ff, wb_vld_in;
   logic [SLOT_W-1:0]       wb_idx_ff, wb_idx_in;
   logic [CFG_W-1:0]        interval_ff, interval_in;
   logic [CLIENT_SLOTS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [CLIENT_SLOTS-1:0] tmr_vld_ff, tmr_vld_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0]    rsp_verdict_ff, rsp_verdict_in;
   logic [TIMER_W-1:0]      rsp_wait_ff, rsp_wait_in;

   logic                    req_acc;
   logic                    msg_acc;
   logic                    tick_acc;
   logic [SLOT_W-1:0]       req_slot;
   logic                    req_slot_ok;
   logic [CFG_W:0]          ivl_next;
   logic                    win_hit;
   logic                    out_free;
   logic                    post_msg;
   logic                    post_tick;

   // ram ports
   logic                    cnt_we;
   logic [COUNT_W-1:0]      cnt_wdata;
   logic [COUNT_W-1:0]      cnt_rdata;
   logic                    tmr_we;
   logic [SLOT_W-1:0]       tmr_waddr;
   logic [TIMER_W-1:0]      tmr_wdata;
   logic                    tmr_re;
   logic [SLOT_W-1:0]       tmr_raddr;
   logic [TIMER_W-1:0]      tmr_rdata;

   // decision datapath
   logic [COUNT_W-1:0]      cur_cnt;
   logic [TIMER_W-1:0]      cur_tmr;
   logic [TIMER_W-1:0]      sw_tmr;
   logic                    over_limit;
   logic                    new_lock;
   logic [VERDICT_W-1:0]    msg_verdict;
   logic [TIMER_W-1:0]      msg_wait;

   pcsrl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // message counts, one entry per slot
   pcsrl_ram #(.WIDTH(COUNT_W), .DEPTH(CLIENT_SLOTS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (slot_ff),
      .wr_data (cnt_wdata),
      .rd_en   (msg_acc),
      .rd_addr (req_slot),
      .rd_data (cnt_rdata)
   );

   // lockout timers, shared between message checks and the tick sweep
   pcsrl_ram #(.WIDTH(TIMER_W), .DEPTH(CLIENT_SLOTS)) u_tmr_ram (
      .clock   (clock),
      .wr_en   (tmr_we),
      .wr_addr (tmr_waddr),
      .wr_data (tmr_wdata),
      .rd_en   (tmr_re),
      .rd_addr (tmr_raddr),
      .rd_data (tmr_rdata)
   );

   // one word at a time: a slot's read-modify-write completes before the
   // next word is taken, so no forwarding between words is needed
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_acc     = req_valid & req_ready;
   assign msg_acc     = req_acc & (req_type == REQ_MSG);
   assign tick_acc    = req_acc & (req_type == REQ_TICK);
   assign req_slot    = SLOT_W'(req_client_slot);
   assign req_slot_ok = (32'(req_client_slot) < 32'(CLIENT_SLOTS));

   // interval counter: a window shrunk below the counter clears at once
   assign ivl_next = {1'b0, interval_ff} + (CFG_W+1)'(1);
   assign win_hit  = (ivl_next >= {1'b0, cfg.window_ticks});

   // output register frees when empty or being taken
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign post_msg  = (state_ff == ST_MSG) & out_free;
   assign post_tick = (state_ff == ST_TDONE) & out_free;

   // timer read: sweep walks the slots, otherwise the message's slot
   assign tmr_re    = msg_acc | (state_ff == ST_SWEEP);
   assign tmr_raddr = (state_ff == ST_SWEEP) ? sweep_idx_ff : req_slot;

   // entries never written since reset read as zero
   assign cur_cnt = cnt_vld_ff[slot_ff]   ? cnt_rdata : '0;
   assign cur_tmr = tmr_vld_ff[slot_ff]   ? tmr_rdata : '0;
   assign sw_tmr  = tmr_vld_ff[wb_idx_ff] ? tmr_rdata : '0;

   assign over_limit = (cur_cnt > {1'b0, cfg.message_limit});

   always_comb begin
      msg_verdict = V_ALLOWED;
      msg_wait    = '0;
      new_lock    = 1'b0;
      cnt_we      = 1'b0;
      if (slot_ok_ff) begin
         if (cur_tmr != '0) begin
            // still locked out: report what is left
            msg_verdict = V_LOCKED;
            msg_wait    = cur_tmr;
         end else if (over_limit) begin
            // start a lockout; a zero length leaves the timer at zero
            msg_verdict = V_NEW_LOCK;
            msg_wait    = cfg.lockout_seconds;
            new_lock    = post_msg;
         end else begin
            cnt_we = post_msg;
         end
      end
   end

   // saturating count increment
   assign cnt_wdata = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_W'(1);

   // timer writeback: sweep decrement or new lockout, never in the same cycle
   always_comb begin
      if (wb_vld_ff) begin
         tmr_we    = 1'b1;
         tmr_waddr = wb_idx_ff;
         tmr_wdata = (sw_tmr != '0) ? sw_tmr - TIMER_W'(1) : sw_tmr;
      end else begin
         tmr_we    = new_lock;
         tmr_waddr = slot_ff;
         tmr_wdata = cfg.lockout_seconds;
      end
   end

   // sequencer and bookkeeping
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      slot_ok_in   = slot_ok_ff;
      sweep_idx_in = sweep_idx_ff;
      wb_vld_in    = (state_ff == ST_SWEEP);
      wb_idx_in    = sweep_idx_ff;
      interval_in  = interval_ff;
      cnt_vld_in   = cnt_vld_ff;
      tmr_vld_in   = tmr_vld_ff;

      case (state_ff)
         ST_IDLE: begin
            if (msg_acc) begin
               slot_in    = req_slot;
               slot_ok_in = req_slot_ok;
               state_in   = ST_MSG;
            end else if (tick_acc) begin
               // window roll clears every count at once via the valid flops
               if (win_hit) begin
                  interval_in = '0;
                  cnt_vld_in  = '0;
               end else begin
                  interval_in = ivl_next[CFG_W-1:0];
               end
               // slot zero is never decremented
               sweep_idx_in = SLOT_FIRST;
               state_in     = ST_SWEEP;
            end
         end
         ST_MSG: begin
            if (post_msg) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_idx_ff == SLOT_LAST) begin
               state_in = ST_TDONE;
            end else begin
               sweep_idx_in = sweep_idx_ff + SLOT_W'(1);
            end
         end
         ST_TDONE: begin
            if (post_tick) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cnt_we) begin
         cnt_vld_in[slot_ff] = 1'b1;
      end
      if (tmr_we) begin
         tmr_vld_in[tmr_waddr] = 1'b1;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_wait_in    = rsp_wait_ff;
      if (post_msg) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = msg_verdict;
         rsp_wait_in    = msg_wait;
      end else if (post_tick) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = V_TICK;
         rsp_wait_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wb_vld_ff    <= 1'b0;
         interval_ff  <= '0;
         cnt_vld_ff   <= '0;
         tmr_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wb_vld_ff    <= wb_vld_in;
         interval_ff  <= interval_in;
         cnt_vld_ff   <= cnt_vld_in;
         tmr_vld_ff   <= tmr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff        <= slot_in;
      slot_ok_ff     <= slot_ok_in;
      sweep_idx_ff   <= sweep_idx_in;
      wb_idx_ff      <= wb_idx_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_wait_ff    <= rsp_wait_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_wait_seconds = rsp_wait_ff;

   // a taken word always leaves the idle state
   `PCSRL_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, state_ff != ST_IDLE, "word accepted but sequencer stayed idle")
   // the sweep never touches slot zero
   `PCSRL_ASSERT_IMP(a_sweep_skips_zero, clock, reset, wb_vld_ff, wb_idx_ff != '0, "sweep wrote the timer of slot zero")
   // no sweep writeback may collide with a message decision
   `PCSRL_ASSERT_IMP(a_no_wb_in_msg, clock, reset, state_ff == ST_MSG, !wb_vld_ff, "sweep writeback during a message decision")
   // a result only appears out of a decision or the end of a sweep
   `PCSRL_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_MSG || $past(state_ff) == ST_TDONE, "result posted from an unexpected state")

endmodule

// File: verif/rate_limiter_scoreboard_pkg.sv
// verdict prediction and result checking for the per-client rate limiter test
// depends on pcsrl_pkg for widths, verdict codes and register indexes
`timescale 1ns / 1ps

package rate_limiter_scoreboard_pkg;

   import pcsrl_pkg::*;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [TIMER_W-1:0]   hold_secs;
   } verdict_word_type;

   class verdict_scoreboard;

      logic [CFG_W-1:0]   msg_limit;
      logic [CFG_W-1:0]   lock_len;
      logic [CFG_W-1:0]   window_len;
      logic [COUNT_W-1:0] msg_count [CLIENT_SLOTS];
      logic [TIMER_W-1:0] lock_timer [CLIENT_SLOTS];
      logic [7:0]         tick_count;

      verdict_word_type verdicts_due [$];
      int unsigned failures;
      int unsigned words_seen;
      int unsigned verdict_tally [4];

      function new();
         msg_limit  = RST_MSG_LIMIT;
         lock_len   = RST_LOCKOUT;
         window_len = RST_WINDOW;
         foreach (msg_count[s]) begin
            msg_count[s]  = '0;
            lock_timer[s] = '0;
         end
         tick_count = '0;
         failures   = 0;
         words_seen = 0;
         foreach (verdict_tally[v]) verdict_tally[v] = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            REG_MSG_LIMIT: msg_limit = value;
            REG_LOCKOUT: lock_len = value;
            REG_WINDOW: window_len = value;
            default: ;
         endcase
      endfunction

      // window counter, count clear, then timers of slot 1 and up count down
      function void advance_tick();
         logic [8:0] next_count;
         int         s;
         next_count = {1'b0, tick_count} + 9'd1;
         if (next_count >= {1'b0, window_len}) begin
            foreach (msg_count[c]) msg_count[c] = '0;
            next_count = '0;
         end
         tick_count = next_count[7:0];
         for (s = 1; s < CLIENT_SLOTS; s++)
            if (lock_timer[s] != '0) lock_timer[s] = lock_timer[s] - 1'b1;
      endfunction

      function void note_word(logic kind, logic [SLOT_IN_W-1:0] slot);
         verdict_word_type due;
         int               idx;
         due.verdict   = V_ALLOWED;
         due.hold_secs = '0;
         idx = int'(slot);
         if (kind == REQ_TICK) begin
            advance_tick();
            due.verdict = V_TICK;
         end else if (idx < CLIENT_SLOTS) begin
            if (lock_timer[idx] != '0) begin
               due.verdict   = V_LOCKED;
               due.hold_secs = lock_timer[idx];
            end else if (msg_count[idx] > {1'b0, msg_limit}) begin
               lock_timer[idx] = lock_len;
               due.verdict     = V_NEW_LOCK;
               due.hold_secs   = lock_len;
            end else if (msg_count[idx] != COUNT_MAX) begin
               msg_count[idx] = msg_count[idx] + 1'b1;
            end
         end
         verdicts_due.push_back(due);
         verdict_tally[due.verdict]++;
         words_seen++;
      endfunction

      function void note_failure(string what);
         failures++;
         if (failures <= 10) $display("mismatch %0d: %s", failures, what);
      endfunction

      function void check_result(logic [VERDICT_W-1:0] verdict, logic [TIMER_W-1:0] hold_secs);
         verdict_word_type due;
         if (verdicts_due.size() == 0) begin
            note_failure($sformatf("result with none due: verdict %0d wait %0d",
                                   verdict, hold_secs));
            return;
         end
         due = verdicts_due.pop_front();
         if (due.verdict !== verdict || due.hold_secs !== hold_secs)
            note_failure($sformatf("verdict exp %0d got %0d, wait exp %0d got %0d",
                                   due.verdict, verdict, due.hold_secs, hold_secs));
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

   endclass

endpackage

// File: verif/per_client_spam_rate_limiter_test.sv
// self-checking test of the per-client rate limiter: directed words, then random
// phases under several register settings; depends on pcsrl_pkg and the scoreboard pkg
`timescale 1ns / 1ps

module per_client_spam_rate_limiter_test;

   import pcsrl_pkg::*;
   import rate_limiter_scoreboard_pkg::*;

   // a tick sweeps the timers of slots 1 and up, so allow a full sweep plus margin before idle
   localparam int SETTLE_CYCLES = CLIENT_SLOTS + 8;

   typedef enum {READY_ALWAYS, READY_COIN, READY_LONG_STALLS} ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_MSG;
   logic [SLOT_IN_W-1:0]  req_client_slot = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [VERDICT_W-1:0]  rsp_verdict;
   logic [TIMER_W-1:0]    rsp_wait_seconds;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   verdict_scoreboard rate_check = new();

   int             burst_left = 0;
   int             settings_run = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_left = 0;
   int             stall_left = 0;

   per_client_spam_rate_limiter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_client_slot  (req_client_slot),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .rsp_wait_seconds (rsp_wait_seconds),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop, far beyond an all-tick run with worst stalls
   initial begin
      #(20_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   // result side stalls on its own schedule: always ready, coin flips, or long holds
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_left = $urandom_range(40, 200);
      end else begin
         ready_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready = 1'b1;
         READY_COIN: rsp_ready = 1'($urandom_range(0, 1));
         default: begin
            if (stall_left != 0) begin
               rsp_ready = 1'b0;
               stall_left--;
            end else begin
               rsp_ready = 1'b1;
               if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 12);
            end
         end
      endcase
   end

   // result words are compared in order against the predicted verdicts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         rate_check.check_result(rsp_verdict, rsp_wait_seconds);
   end

   // register write: setup cycle, then access cycle; called at a falling edge
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rate_check.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic write_all(logic [CFG_W-1:0] limit, logic [CFG_W-1:0] lockout,
                            logic [CFG_W-1:0] window);
      csr_write(REG_MSG_LIMIT, limit);
      csr_write(REG_LOCKOUT, lockout);
      csr_write(REG_WINDOW, window);
      settings_run++;
   endtask

   // sender pause: every due verdict back, then let a tick sweep finish
   task automatic drain_and_settle();
      req_valid = 1'b0;
      while (rate_check.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one word; valid stays high into the next call while a burst lasts
   task automatic put_word(logic kind, logic [SLOT_IN_W-1:0] slot);
      int gap;
      req_valid       = 1'b1;
      req_type        = kind;
      req_client_slot = slot;
      do @(posedge clock); while (!req_ready);
      rate_check.note_word(kind, slot);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // about a quarter of burst ends run straight into the next burst
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
   endtask

   // random phase: mostly traffic from a few hot slots so limits and lockouts
   // are reached, the rest spread over all slots, ticks mixed in
   task automatic run_phase(logic [CFG_W-1:0] limit, logic [CFG_W-1:0] lockout,
                            logic [CFG_W-1:0] window, int words, int tick_pct,
                            int hot_n, int hot_pct);
      logic [SLOT_IN_W-1:0] hot_slots [4];
      logic [SLOT_IN_W-1:0] slot;
      logic                 kind;
      int                   i;
      drain_and_settle();
      write_all(limit, lockout, window);
      foreach (hot_slots[h])
         hot_slots[h] = SLOT_IN_W'($urandom_range(0, CLIENT_SLOTS - 1));
      for (i = 0; i < words; i++) begin
         kind = ($urandom_range(1, 100) <= tick_pct) ? REQ_TICK : REQ_MSG;
         if ($urandom_range(1, 100) <= hot_pct)
            slot = hot_slots[2'($urandom_range(0, hot_n - 1))];
         else
            slot = SLOT_IN_W'($urandom_range(0, CLIENT_SLOTS - 1));
         put_word(kind, slot);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset settings: slot 0 runs past the limit, and ticks never free it
      repeat (7) put_word(REQ_MSG, 6'd0);
      put_word(REQ_MSG, 6'd0);
      put_word(REQ_TICK, 6'h3F);
      put_word(REQ_MSG, 6'd0);
      put_word(REQ_MSG, 6'd63);
      put_word(REQ_MSG, 6'd42);
      put_word(REQ_MSG, 6'd21);
      put_word(REQ_TICK, 6'd0);

      // zero limit, zero lockout length, zero window
      drain_and_settle();
      write_all(8'd0, 8'd0, 8'd0);
      put_word(REQ_MSG, 6'd1);
      put_word(REQ_MSG, 6'd1);
      put_word(REQ_MSG, 6'd1);
      put_word(REQ_TICK, 6'd1);
      put_word(REQ_MSG, 6'd1);

      // top settings, four ticks, then the window shrinks below the counter
      drain_and_settle();
      write_all(8'd255, 8'd255, 8'd255);
      repeat (4) put_word(REQ_TICK, 6'd0);
      drain_and_settle();
      csr_write(REG_WINDOW, 8'd2);
      put_word(REQ_TICK, 6'd0);
      put_word(REQ_MSG, 6'd1);

      run_phase(8'd5, 8'd10, 8'd5, 130, 8, 3, 85);
      run_phase(8'd0, 8'd1, 8'd1, 110, 10, 4, 80);
      // top limit: one slot takes nearly all words so it still locks out
      run_phase(8'd255, 8'd255, 8'd255, 300, 1, 1, 98);
      run_phase(8'd2, 8'd0, 8'd0, 100, 10, 3, 80);
      run_phase(8'd3, 8'd4, 8'd3, 150, 15, 2, 80);
      run_phase(CFG_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 255)),
                CFG_W'($urandom_range(0, 255)), 160, 8, 4, 80);

      drain_and_settle();
      $display("run covered %0d words: %0d allowed, %0d still locked, %0d new lockouts,",
               rate_check.words_seen, rate_check.verdict_tally[V_ALLOWED],
               rate_check.verdict_tally[V_LOCKED], rate_check.verdict_tally[V_NEW_LOCK]);
      $display("%0d ticks, over %0d register settings from zero to full scale",
               rate_check.verdict_tally[V_TICK], settings_run);
      if (rate_check.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches in total", rate_check.failures);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
